FILE: src/spdf_pkg.sv
// Shared types and constants for the sync packet deframer with Fletcher check.
package spdf_pkg;

    localparam int BYTE_W  = 8;
    localparam int CHECK_W = 16;
    localparam int CFG_IDX_W = 8;
    // Output tdata: 65 bits of fields padded to whole bytes
    localparam int OUT_DATA_W = 72;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 8'd1;

    // Reset values of the sync registers
    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'd117;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'd101;

    // Frame phases
    typedef enum logic [2:0] {
        PH_SYNC1   = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_SET     = 3'd2,
        PH_LEN     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CKHI    = 3'd5,
        PH_CKLO    = 3'd6
    } t_phase;

    // One result item
    typedef struct packed {
        logic                 is_end;
        logic [BYTE_W-1:0]    data_byte;
        logic [BYTE_W-1:0]    byte_index;
        logic [BYTE_W-1:0]    descriptor_set;
        logic [BYTE_W-1:0]    payload_length;
        logic                 status;
        logic [CHECK_W-1:0]   received_check;
        logic [CHECK_W-1:0]   computed_check;
    } t_result;

endpackage

FILE: src/spdf_core.sv
// Frame tracker: phase, counters and running sums, builds one result per payload byte and one at the packet end.
module spdf_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,        // process i_byte this cycle
    input  logic [spdf_pkg::BYTE_W-1:0] i_byte,
    input  logic [spdf_pkg::BYTE_W-1:0] i_sync_first,
    input  logic [spdf_pkg::BYTE_W-1:0] i_sync_second,
    output logic                      o_res_valid,
    output spdf_pkg::t_result         o_res
);
    import spdf_pkg::*;

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_len, n_len;
    logic [BYTE_W-1:0] r_cnt, n_cnt;
    logic [BYTE_W-1:0] r_set, n_set;
    logic [BYTE_W-1:0] r_sum1, n_sum1;
    logic [BYTE_W-1:0] r_sum2, n_sum2;
    logic [BYTE_W-1:0] r_ckhi, n_ckhi;

    logic [BYTE_W-1:0] add1, add2;
    logic [BYTE_W-1:0] cnt_inc;
    logic [CHECK_W-1:0] rcv_check, cmp_check;

    // Fletcher step and helpers
    always_comb begin
        add1      = r_sum1 + i_byte;
        add2      = r_sum2 + add1;
        cnt_inc   = r_cnt + 8'd1;
        rcv_check = {r_ckhi, i_byte};
        cmp_check = {r_sum1, r_sum2};
    end

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_cnt   = r_cnt;
        n_set   = r_set;
        n_sum1  = r_sum1;
        n_sum2  = r_sum2;
        n_ckhi  = r_ckhi;
        case (r_phase)
            PH_SYNC2: begin
                if (i_byte == i_sync_second) begin
                    n_sum1  = add1;
                    n_sum2  = add2;
                    n_phase = PH_SET;
                end else if (i_byte == i_sync_first) begin
                    // restart on a fresh first sync byte
                    n_sum1  = i_byte;
                    n_sum2  = i_byte;
                    n_phase = PH_SYNC2;
                end else begin
                    n_phase = PH_SYNC1;
                end
            end
            PH_SET: begin
                n_set   = i_byte;
                n_sum1  = add1;
                n_sum2  = add2;
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                n_len   = i_byte;
                n_cnt   = '0;
                n_sum1  = add1;
                n_sum2  = add2;
                n_phase = (i_byte == '0) ? PH_CKHI : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                n_sum1 = add1;
                n_sum2 = add2;
                if (cnt_inc >= r_len) begin
                    n_phase = PH_CKHI;
                end else begin
                    n_cnt = cnt_inc;
                end
            end
            PH_CKHI: begin
                n_ckhi  = i_byte;
                n_phase = PH_CKLO;
            end
            PH_CKLO: begin
                n_phase = PH_SYNC1;
            end
            default: begin
                if (i_byte == i_sync_first) begin
                    n_sum1  = i_byte;
                    n_sum2  = i_byte;
                    n_phase = PH_SYNC2;
                end else begin
                    n_phase = PH_SYNC1;
                end
            end
        endcase
    end

    // Result build
    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.descriptor_set = r_set;
        o_res.payload_length = r_len;
        case (r_phase)
            PH_PAYLOAD: begin
                o_res_valid     = i_step;
                o_res.data_byte = i_byte;
                o_res.byte_index = r_cnt;
            end
            PH_CKLO: begin
                o_res_valid          = i_step;
                o_res.is_end         = 1'b1;
                o_res.status         = (rcv_check != cmp_check);
                o_res.received_check = rcv_check;
                o_res.computed_check = cmp_check;
            end
            default: begin
                o_res_valid = 1'b0;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC1;
            r_len   <= '0;
            r_cnt   <= '0;
            r_set   <= '0;
            r_sum1  <= '0;
            r_sum2  <= '0;
            r_ckhi  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_set   <= n_set;
            r_sum1  <= n_sum1;
            r_sum2  <= n_sum2;
            r_ckhi  <= n_ckhi;
        end
    end

endmodule

FILE: src/spdf_out_reg.sv
// Result register toward the master-side stream.
module spdf_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  spdf_pkg::t_result i_res,
    input  logic              i_ready,
    output logic              o_can_load,
    output logic              o_valid,
    output spdf_pkg::t_result o_res
);
    import spdf_pkg::*;

    logic    r_valid, n_valid;
    t_result r_res;

    // Room when empty or the held result leaves this cycle
    assign o_can_load = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

FILE: src/sync_packet_deframer_fletcher_top.sv
// Top level of the sync packet deframer with Fletcher-style checksum.
//
// Slave stream: one received serial byte per transfer in s_axis_tdata.
// Master stream: one result per payload byte (tlast low) and one packet
// end result (tlast high) carrying the good/bad status and both checks.
// Config channel: index 0 writes the first sync byte, index 1 the second;
// other indexes are ignored. Writes are always accepted and belong in
// idle periods only.
// Path: a byte is held in the input register and its result is loaded into
// the result register when the byte is processed, which raises m_axis_tvalid;
// a stall on the master side can hold the byte between the two. Throughput
// is one byte per cycle while the master side takes results, set by the state
// update between the two registers.
// Bytes that produce no result (sync, set, length, checksum high) pass
// through the input register and leave nothing behind.
// Reset: hunting for the first sync byte, sums and counters zero, sync
// registers at 117 and 101, both stream registers empty.
// Stall: a held result blocks the input register, which then stops the
// slave side; no byte or result is lost.
module sync_packet_deframer_fletcher_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // slave stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [spdf_pkg::BYTE_W-1:0]          s_axis_tdata,  // [7:0] rx_byte
    // master stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [7:0] data_byte, [15:8] byte_index, [23:16] descriptor_set,
    // [31:24] payload_length, [32] status, [48:33] received_check,
    // [64:49] computed_check, [71:65] zero
    output logic [spdf_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                                 m_axis_tlast,  // is_end
    // configuration write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [spdf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [spdf_pkg::BYTE_W-1:0]          i_cfg_data
);
    import spdf_pkg::*;

    logic [BYTE_W-1:0] r_sync_first;
    logic [BYTE_W-1:0] r_sync_second;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    logic    step;
    logic    can_load;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign o_cfg_ready = 1'b1;

    // Sync byte registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= SYNC_FIRST_RST;
            r_sync_second <= SYNC_SECOND_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_SYNC_FIRST) begin
                r_sync_first <= i_cfg_data;
            end else if (i_cfg_index == CFG_SYNC_SECOND) begin
                r_sync_second <= i_cfg_data;
            end
        end
    end

    // Input register: byte is processed once the result register has room
    assign step          = r_in_valid && can_load;
    assign s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    spdf_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_byte        (r_in_byte),
        .i_sync_first  (r_sync_first),
        .i_sync_second (r_sync_second),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    spdf_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (res_valid),
        .i_res      (res),
        .i_ready    (m_axis_tready),
        .o_can_load (can_load),
        .o_valid    (m_axis_tvalid),
        .o_res      (out_res)
    );

    // Pack the result fields, lowest field first
    assign m_axis_tlast = out_res.is_end;
    assign m_axis_tdata = {7'd0,
                           out_res.computed_check,
                           out_res.received_check,
                           out_res.status,
                           out_res.payload_length,
                           out_res.descriptor_set,
                           out_res.byte_index,
                           out_res.data_byte};

endmodule

FILE: tb/sv/tb_sync_packet_deframer_fletcher_top.sv
// Self-checking testbench for the sync packet deframer with Fletcher-style checksum.
`timescale 1ns / 1ps

module tb_sync_packet_deframer_fletcher_top;
    import spdf_pkg::*;

    // Register indexes outside the register list; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 8'hFF;
    localparam int LATENCY_WAIT = 4;

    // DUT ports; the inputs start at known values from time zero
    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [BYTE_W-1:0]        s_axis_tdata  = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]    m_axis_tdata;
    logic                     m_axis_tlast;
    logic                     i_cfg_valid   = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index   = '0;
    logic [BYTE_W-1:0]        i_cfg_data    = '0;

    // Bytes waiting for the driver, results waiting for the monitor
    logic [BYTE_W-1:0] pending_bytes[$];
    t_result           expected_results[$];
    int                bytes_queued   = 0;
    int                mismatch_count = 0;
    int                results_seen   = 0;
    int                idle_pct       = 0;
    int                src_gap        = 0;
    int                sink_gap       = 0;

    // Deframer model state and its copy of the sync registers
    t_phase            frm_phase = PH_SYNC1;
    logic [BYTE_W-1:0] len_seen  = '0;
    logic [BYTE_W-1:0] pay_cnt   = '0;
    logic [BYTE_W-1:0] set_byte  = '0;
    logic [BYTE_W-1:0] sum_a     = '0;
    logic [BYTE_W-1:0] sum_b     = '0;
    logic [BYTE_W-1:0] ck_hi     = '0;
    logic [BYTE_W-1:0] cfg_sync1 = SYNC_FIRST_RST;
    logic [BYTE_W-1:0] cfg_sync2 = SYNC_SECOND_RST;

    sync_packet_deframer_fletcher_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] rx_byte
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // [7:0] data_byte, [15:8] byte_index, [23:16] descriptor_set,
        // [31:24] payload_length, [32] status, [48:33] received_check,
        // [64:49] computed_check, [71:65] zero
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),   // is_end
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Fletcher running sums, both modulo 256
    function automatic void fold_byte(input logic [BYTE_W-1:0] b);
        sum_a = sum_a + b;
        sum_b = sum_b + sum_a;
    endfunction

    function automatic void open_frame(input logic [BYTE_W-1:0] b);
        sum_a = '0;
        sum_b = '0;
        fold_byte(b);
        frm_phase = PH_SYNC2;
    endfunction

    // Advance the deframer model by one received byte, queue any result
    task automatic predict_byte(input logic [BYTE_W-1:0] b);
        t_result r;
        bit      hit;
        r   = '0;
        hit = 1'b0;
        case (frm_phase)
            PH_SYNC2: begin
                if (b == cfg_sync2) begin
                    fold_byte(b);
                    frm_phase = PH_SET;
                end else if (b == cfg_sync1) begin
                    open_frame(b);
                end else begin
                    frm_phase = PH_SYNC1;
                end
            end
            PH_SET: begin
                set_byte = b;
                fold_byte(b);
                frm_phase = PH_LEN;
            end
            PH_LEN: begin
                len_seen = b;
                pay_cnt  = '0;
                fold_byte(b);
                frm_phase = (b == 8'd0) ? PH_CKHI : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                fold_byte(b);
                r.data_byte      = b;
                r.byte_index     = pay_cnt;
                r.descriptor_set = set_byte;
                r.payload_length = len_seen;
                hit = 1'b1;
                if (BYTE_W'(pay_cnt + 8'd1) >= len_seen) frm_phase = PH_CKHI;
                else pay_cnt = pay_cnt + 8'd1;
            end
            PH_CKHI: begin
                ck_hi = b;
                frm_phase = PH_CKLO;
            end
            PH_CKLO: begin
                r.is_end         = 1'b1;
                r.descriptor_set = set_byte;
                r.payload_length = len_seen;
                r.received_check = {ck_hi, b};
                r.computed_check = {sum_a, sum_b};
                r.status         = ({ck_hi, b} != {sum_a, sum_b});
                hit = 1'b1;
                frm_phase = PH_SYNC1;
            end
            default: begin
                if (b == cfg_sync1) open_frame(b);
                else frm_phase = PH_SYNC1;
            end
        endcase
        if (hit) expected_results.push_back(r);
    endtask

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            flag_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                    results_seen, name, got, want));
    endtask

    // Driver: feeds one byte per transfer from the pending queue
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) predict_byte(s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                    src_gap = $urandom_range(0, 18);
                    s_axis_tvalid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    s_axis_tdata  <= pending_bytes.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transfer against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    flag_mismatch($sformatf("result %0d arrived with nothing expected",
                                            results_seen));
                end else begin
                    check_field("is_end", 16'(m_axis_tlast),
                                16'(expected_results[0].is_end));
                    check_field("data_byte", 16'(m_axis_tdata[7:0]),
                                16'(expected_results[0].data_byte));
                    check_field("byte_index", 16'(m_axis_tdata[15:8]),
                                16'(expected_results[0].byte_index));
                    check_field("descriptor_set", 16'(m_axis_tdata[23:16]),
                                16'(expected_results[0].descriptor_set));
                    check_field("payload_length", 16'(m_axis_tdata[31:24]),
                                16'(expected_results[0].payload_length));
                    check_field("status", 16'(m_axis_tdata[32]),
                                16'(expected_results[0].status));
                    check_field("received_check", m_axis_tdata[48:33],
                                expected_results[0].received_check);
                    check_field("computed_check", m_axis_tdata[64:49],
                                expected_results[0].computed_check);
                    check_field("pad", 16'(m_axis_tdata[71:65]), 16'd0);
                    void'(expected_results.pop_front());
                end
                results_seen++;
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                sink_gap = $urandom_range(0, 18);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic queue_byte(input logic [BYTE_W-1:0] b);
        pending_bytes.push_back(b);
        bytes_queued++;
    endtask

    // Whole frame with a correct check, or one with a flipped check bit
    task automatic push_packet(input logic [BYTE_W-1:0] s1, input logic [BYTE_W-1:0] s2,
                               input logic [BYTE_W-1:0] set_b, input logic [BYTE_W-1:0] len,
                               input bit corrupt, input int fill);
        logic [BYTE_W-1:0]  frame_q[$];
        logic [BYTE_W-1:0]  a;
        logic [BYTE_W-1:0]  c;
        logic [CHECK_W-1:0] ck;
        frame_q = '{s1, s2, set_b, len};
        repeat (len) frame_q.push_back((fill < 0) ? BYTE_W'($urandom) : BYTE_W'(fill));
        a = '0;
        c = '0;
        foreach (frame_q[k]) begin
            a = a + frame_q[k];
            c = c + a;
        end
        ck = {a, c};
        if (corrupt) ck = ck ^ (CHECK_W'(1) << $urandom_range(0, CHECK_W - 1));
        frame_q.push_back(ck[15:8]);
        frame_q.push_back(ck[7:0]);
        foreach (frame_q[k]) queue_byte(frame_q[k]);
    endtask

    // Mostly good frames, some noise, broken sync pairs and cut-off frames
    task automatic random_traffic(input logic [BYTE_W-1:0] s1, input logic [BYTE_W-1:0] s2,
                                  input int n);
        int                start;
        int                pick;
        logic [BYTE_W-1:0] len;
        start = bytes_queued;
        while (bytes_queued - start < n) begin
            pick = $urandom_range(0, 99);
            len  = BYTE_W'($urandom_range(0, 12));
            if (pick < 70) begin
                push_packet(s1, s2, BYTE_W'($urandom), len, $urandom_range(0, 4) == 0, -1);
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 4)) queue_byte(BYTE_W'($urandom));
            end else if (pick < 88) begin
                queue_byte(s1);
                queue_byte(BYTE_W'($urandom));
            end else if (pick < 94) begin
                queue_byte(s1);
                push_packet(s1, s2, BYTE_W'($urandom), len, 1'b0, -1);
            end else begin
                queue_byte(s1);
                queue_byte(s2);
                queue_byte(BYTE_W'($urandom));
                queue_byte(len);
                repeat ($urandom_range(0, len)) queue_byte(BYTE_W'($urandom));
            end
        end
    endtask

    // Wait until every byte is taken and every result seen, then let the pipe empty
    task automatic wait_drained();
        int quiet;
        quiet = 0;
        while (quiet < LATENCY_WAIT) begin
            @(posedge i_clk);
            if (pending_bytes.size() == 0 && !s_axis_tvalid && expected_results.size() == 0)
                quiet++;
            else
                quiet = 0;
        end
    endtask

    // Feed non-sync bytes until the deframer is back to hunting
    task automatic flush_to_hunt();
        logic [BYTE_W-1:0] filler;
        filler = 8'h00;
        while (filler == cfg_sync1 || filler == cfg_sync2) filler = filler + 8'd1;
        wait_drained();
        while (frm_phase != PH_SYNC1) begin
            queue_byte(filler);
            wait_drained();
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_SYNC_FIRST) cfg_sync1 = val;
        else if (idx == CFG_SYNC_SECOND) cfg_sync2 = val;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [BYTE_W-1:0] s1, input logic [BYTE_W-1:0] s2,
                             input logic [CFG_IDX_W-1:0] junk_idx, input int pct,
                             input bit with_long, input int n);
        wait_drained();
        cfg_write(CFG_SYNC_FIRST, s1);
        cfg_write(CFG_SYNC_SECOND, s2);
        cfg_write(junk_idx, BYTE_W'($urandom));
        idle_pct = pct;
        // longest payload: byte index runs up to 254
        if (with_long) push_packet(s1, s2, BYTE_W'($urandom), 8'hFF, 1'b0, -1);
        random_traffic(s1, s2, n);
        flush_to_hunt();
    endtask

    // Stimulus: reset, directed frames, then random phases over several sync settings
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct = 20;
        queue_byte(8'h00);
        queue_byte(8'hFF);
        // empty payload, checksum right after the length
        push_packet(SYNC_FIRST_RST, SYNC_SECOND_RST, 8'hFF, 8'd0, 1'b0, -1);
        // first sync repeated where the second is due
        queue_byte(SYNC_FIRST_RST);
        push_packet(SYNC_FIRST_RST, SYNC_SECOND_RST, 8'h00, 8'd2, 1'b0, 8'hFF);
        // wrong second sync, then a frame with a bad check
        queue_byte(SYNC_FIRST_RST);
        queue_byte(8'h33);
        push_packet(SYNC_FIRST_RST, SYNC_SECOND_RST, 8'h80, 8'd1, 1'b1, 8'h00);
        flush_to_hunt();

        run_phase(SYNC_FIRST_RST, SYNC_SECOND_RST, CFG_UNUSED_LO, 20, 1'b0, 190);
        run_phase(8'h00, 8'hFF, CFG_UNUSED_HI, 30, 1'b0, 190);
        run_phase(8'hFF, 8'h00, CFG_UNUSED_LO, 0, 1'b1, 190);
        // both sync values equal
        run_phase(8'h5A, 8'h5A, CFG_UNUSED_HI, 25, 1'b0, 190);
        run_phase(BYTE_W'($urandom), BYTE_W'($urandom), CFG_UNUSED_LO, 15, 1'b0, 190);
        // last part runs without idling
        run_phase(BYTE_W'($urandom), BYTE_W'($urandom), CFG_UNUSED_HI, 0, 1'b0, 190);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Run limit, far beyond the slowest correct run
    initial begin
        #(64'd20_000_000);
        $display("Mismatches found");
        $finish;
    end

endmodule
